// ----- hw/rtl/wsd_pkg.sv -----
// shared types and constants for the websocket frame deframer
// no dependencies; used by wsd_parser and websocket_frame_deframer
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } wsd_phase_t;

  localparam logic [6:0] LEN16_CODE   = 7'd126;
  localparam logic [6:0] LEN64_CODE   = 7'd127;
  localparam logic [2:0] EXT16_COUNT  = 3'd1;
  localparam logic [2:0] EXT64_COUNT  = 3'd7;
  localparam logic [2:0] KEY_COUNT    = 3'd3;
  localparam logic       KIND_HEADER  = 1'b0;
  localparam logic       KIND_PAYLOAD = 1'b1;

  typedef struct packed {
    logic        kind;
    logic        fin_bit;
    logic [2:0]  rsv_bits;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last;
  } wsd_result_t;

  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
    logic [7:0] kb;
    case (idx)
      2'd0:    kb = key[31:24];
      2'd1:    kb = key[23:16];
      2'd2:    kb = key[15:8];
      default: kb = key[7:0];
    endcase
    return kb;
  endfunction

endpackage

// ----- hw/rtl/wsd_parser.sv -----
// frame parser: phase state machine, length and key collection, payload unmasking
// depends on wsd_pkg; produces at most one result per accepted word
module wsd_parser import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  output wsd_result_t res
);

  wsd_phase_t  phase, phase_next;
  logic [2:0]  byte_count, byte_count_next;
  logic [7:0]  first_byte_fields, first_byte_fields_next;
  logic        mask_flag, mask_flag_next;
  logic [63:0] length_accum, length_accum_next;
  logic [31:0] mask_key, mask_key_next;
  logic [63:0] remaining, remaining_next;
  logic [1:0]  key_index, key_index_next;

  logic        after_len;
  logic        fin_header;
  logic [63:0] rem_dec;
  logic        hdr_last;

  assign rem_dec  = remaining - 64'd1;
  assign hdr_last = (length_accum_next == 64'd0);

  always_comb begin
    phase_next             = phase;
    byte_count_next        = byte_count;
    first_byte_fields_next = first_byte_fields;
    mask_flag_next         = mask_flag;
    length_accum_next      = length_accum;
    mask_key_next          = mask_key;
    remaining_next         = remaining;
    key_index_next         = key_index;
    after_len              = 1'b0;
    fin_header             = 1'b0;
    res_valid              = 1'b0;
    res                    = '0;

    unique case (phase)
      PH_SECOND: begin
        mask_flag_next = rx_byte[7];
        if (rx_byte[6:0] == LEN16_CODE) begin
          length_accum_next = '0;
          byte_count_next   = EXT16_COUNT;
          phase_next        = PH_EXTLEN;
        end else if (rx_byte[6:0] == LEN64_CODE) begin
          length_accum_next = '0;
          byte_count_next   = EXT64_COUNT;
          phase_next        = PH_EXTLEN;
        end else begin
          length_accum_next = {57'd0, rx_byte[6:0]};
          after_len         = 1'b1;
        end
      end
      PH_EXTLEN: begin
        length_accum_next = {length_accum[55:0], rx_byte};
        if (byte_count == 3'd0) begin
          after_len = 1'b1;
        end else begin
          byte_count_next = byte_count - 3'd1;
        end
      end
      PH_KEY: begin
        mask_key_next = {mask_key[23:0], rx_byte};
        if (byte_count == 3'd0) begin
          fin_header = 1'b1;
        end else begin
          byte_count_next = byte_count - 3'd1;
        end
      end
      PH_PAYLOAD: begin
        remaining_next     = rem_dec;
        key_index_next     = key_index + 2'd1;
        res_valid          = 1'b1;
        res.kind           = KIND_PAYLOAD;
        res.payload_byte   = mask_flag ? (rx_byte ^ key_byte(mask_key, key_index)) : rx_byte;
        res.last           = (rem_dec == 64'd0);
        if (rem_dec == 64'd0) begin
          phase_next = PH_FIRST;
        end
      end
      default: begin
        first_byte_fields_next = rx_byte;
        mask_flag_next         = 1'b0;
        length_accum_next      = '0;
        mask_key_next          = '0;
        remaining_next         = '0;
        key_index_next         = '0;
        byte_count_next        = '0;
        phase_next             = PH_SECOND;
      end
    endcase

    if (after_len) begin
      mask_key_next = '0;
      if (mask_flag_next) begin
        byte_count_next = KEY_COUNT;
        phase_next      = PH_KEY;
      end else begin
        fin_header = 1'b1;
      end
    end

    if (fin_header) begin
      remaining_next   = length_accum_next;
      key_index_next   = '0;
      phase_next       = hdr_last ? PH_FIRST : PH_PAYLOAD;
      res_valid        = 1'b1;
      res.kind         = KIND_HEADER;
      res.payload_byte = '0;
      res.last         = hdr_last;
    end

    res.fin_bit        = first_byte_fields_next[7];
    res.rsv_bits       = first_byte_fields_next[6:4];
    res.opcode         = first_byte_fields_next[3:0];
    res.masked         = mask_flag_next;
    res.payload_length = length_accum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_FIRST;
      byte_count        <= '0;
      first_byte_fields <= '0;
      mask_flag         <= 1'b0;
      length_accum      <= '0;
      mask_key          <= '0;
      remaining         <= '0;
      key_index         <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      byte_count        <= byte_count_next;
      first_byte_fields <= first_byte_fields_next;
      mask_flag         <= mask_flag_next;
      length_accum      <= length_accum_next;
      mask_key          <= mask_key_next;
      remaining         <= remaining_next;
      key_index         <= key_index_next;
    end
  end

endmodule

// ----- hw/rtl/websocket_frame_deframer.sv -----
// websocket frame deframer: takes one stream byte per word, yields header and payload words
// channels: in_valid/in_stall with rx_byte; out_valid/out_stall with the result fields
// depends on wsd_pkg and wsd_parser
//
// usage:
//   every accepted input word is one byte of a back-to-back frame stream
//   a header word (kind 0) comes out when the header, with any extended length
//   and masking key, is complete; then one payload word (kind 1) per payload byte,
//   already unmasked; last marks the final word of each frame (the header word
//   itself when the length is zero)
//   each result is registered in the output stage, or in the skid stage when the output word is held
//   throughput: one byte per cycle while in_stall is low, set by the single parser stage
//   the output register is backed by a one-word skid stage, so a byte is still
//   taken while a result waits; in_stall rises only when both are full, and comes
//   straight from a register
//   reset (rst, synchronous) returns the parser to the first header byte and
//   empties both output stages
//   while out_valid and out_stall are both high the output word holds steady
module websocket_frame_deframer import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic        fin_bit,
  output logic [2:0]  rsv_bits,
  output logic [3:0]  opcode,
  output logic        masked,
  output logic [63:0] payload_length,
  output logic [7:0]  payload_byte,
  output logic        last
);

  logic        accept;
  logic        res_valid;
  wsd_result_t res;
  wsd_result_t out_res;
  wsd_result_t skid_res;
  logic        skid_valid;
  logic        out_free;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || (accept && res_valid);
      skid_valid <= 1'b0;
    end else if (accept && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept && res_valid) begin
        out_res <= res;
      end
    end else if (accept && res_valid) begin
      skid_res <= res;
    end
  end

  assign kind           = out_res.kind;
  assign fin_bit        = out_res.fin_bit;
  assign rsv_bits       = out_res.rsv_bits;
  assign opcode         = out_res.opcode;
  assign masked         = out_res.masked;
  assign payload_length = out_res.payload_length;
  assign payload_byte   = out_res.payload_byte;
  assign last           = out_res.last;

  // skid stage only fills behind a held output word
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid word present with empty output stage");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_HEADER) |-> (last == (payload_length == 64'd0)))
    else $error("header word last flag disagrees with payload length");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_HEADER) |-> (payload_byte == 8'd0))
    else $error("header word carries a payload byte");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && skid_valid) |=> (out_valid && skid_valid))
    else $error("stalled output lost a buffered word");

endmodule
